[src/cvg_pkg.sv]
// Shared constants, codes and types for the cylinder vertex generator.
// Used by the front, queue and back modules and by the top level.
// No dependencies.
package cvg_pkg;

	// mesh and arithmetic sizing
	localparam int MAX_SLICES    = 4096;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
	localparam int TEX_W         = 15;
	localparam int PIPE_N        = (CORDIC_N > TEX_W) ? CORDIC_N : TEX_W;

	// field widths
	localparam int VIDX_W    = 15;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 3;
	localparam int FIELD_W   = 16;
	localparam int SLICE_W   = 13;
	localparam int S_CAP     = (MAX_SLICES < (1 << SLICE_W)) ? MAX_SLICES : (1 << SLICE_W) - 1;
	localparam int IDX_W     = $clog2(S_CAP);
	localparam int S_MIN     = 3;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// CORDIC constants: angle in 2^-32 turn, vectors in Q2.30
	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int ATAN_TURN [ATAN_ENTRIES] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// fixed-point ones
	localparam logic signed [FIELD_W-1:0] ONE_Q14  = 16'sd16384;
	localparam logic [FIELD_W-1:0]        ONE_Q15  = 16'd32768;
	localparam logic [FIELD_W-1:0]        HALF_Q15 = 16'd16384;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd3;

	// vertex kinds
	localparam logic [2:0] K_ERR    = 3'd0;
	localparam logic [2:0] K_BODY   = 3'd1;
	localparam logic [2:0] K_BCLOSE = 3'd2;
	localparam logic [2:0] K_CENTER = 3'd3;
	localparam logic [2:0] K_RING   = 3'd4;
	localparam logic [2:0] K_CCLOSE = 3'd5;

	typedef struct packed {
		logic [CFG_W-1:0]   radius;
		logic [CFG_W-1:0]   half_length;
		logic [SLICE_W-1:0] slices;
		logic [CFG_W-1:0]   phase_step;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               top;
		logic [15:0]        phase;
		logic [IDX_W-1:0]   m;
	} item_t;

	typedef struct packed {
		logic                valid;
		logic [2:0]          kind;
		logic                top;
		logic [1:0]          quad;
		logic signed [31:0]  x;
		logic signed [31:0]  y;
		logic signed [31:0]  z;
		logic [SLICE_W-1:0]  rem;
		logic [TEX_W-1:0]    quo;
	} stage_t;

	typedef struct packed {
		logic                       valid;
		logic [2:0]                 kind;
		logic                       top;
		logic signed [FIELD_W-1:0]  c;
		logic signed [FIELD_W-1:0]  s;
		logic [TEX_W-1:0]           quo;
	} fin_t;

endpackage

[src/cylinder_vertex_generator_top.sv]
// Cylinder vertex generator: one vertex (position, normal, texture) per index.
// Throughput: one vertex per cycle; the 16-stage CORDIC/divider pipeline and
// the output register stall together when the result is not taken.
// Reset: config registers return to radius 256, half length 256, 16 slices,
// step 4096; pipeline and queue empty. Depends on cvg_pkg, cvg_front,
// cvg_queue and cvg_back.
module cylinder_vertex_generator_top import cvg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [VIDX_W-1:0]         vertex_index,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] pos_x,
	output logic signed [FIELD_W-1:0] pos_y,
	output logic signed [FIELD_W-1:0] pos_z,
	output logic signed [FIELD_W-1:0] norm_x,
	output logic signed [FIELD_W-1:0] norm_y,
	output logic signed [FIELD_W-1:0] norm_z,
	output logic [FIELD_W-1:0]        tex_s,
	output logic [FIELD_W-1:0]        tex_t,
	output logic                      index_error
);

	logic [CFG_W-1:0]   radius_q, half_length_q, phase_step_q;
	logic [SLICE_W-1:0] slice_count_q, slices_sat;
	cfg_t               cfg;

	logic  push, q_full, q_pop, q_empty;
	item_t push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= CFG_W'(256);
			half_length_q <= CFG_W'(256);
			slice_count_q <= SLICE_W'(16);
			phase_step_q  <= CFG_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RADIUS:      radius_q      <= cfg_data;
				CFG_HALF_LENGTH: half_length_q <= cfg_data;
				CFG_SLICE_COUNT: slice_count_q <= cfg_data[SLICE_W-1:0];
				CFG_PHASE_STEP:  phase_step_q  <= cfg_data;
				default:         radius_q      <= radius_q;
			endcase
		end
	end

	always_comb begin
		priority if (slice_count_q < SLICE_W'(S_MIN)) begin
			slices_sat = SLICE_W'(S_MIN);
		end else if (slice_count_q > SLICE_W'(S_CAP)) begin
			slices_sat = SLICE_W'(S_CAP);
		end else begin
			slices_sat = slice_count_q;
		end
	end

	always_comb begin
		cfg.radius      = radius_q;
		cfg.half_length = half_length_q;
		cfg.slices      = slices_sat;
		cfg.phase_step  = phase_step_q;
	end

	cvg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.vertex_index (vertex_index),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	cvg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	cvg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_empty     (q_empty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.norm_x      (norm_x),
		.norm_y      (norm_y),
		.norm_z      (norm_z),
		.tex_s       (tex_s),
		.tex_t       (tex_t),
		.index_error (index_error)
	);

endmodule

[src/cvg_front.sv]
// Front end: accepts vertex indexes, classifies them into mesh sections and
// computes the rotation phase. Depends on cvg_pkg; feeds cvg_queue.
module cvg_front import cvg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [VIDX_W-1:0] vertex_index,
	output logic              push,
	output item_t             push_item,
	input  logic              q_full
);

	logic [VIDX_W:0] s_ext, body_end, base1, base2, last_idx, n_ext, rel, rel_m1;
	logic            upper;
	logic [2:0]      kind_c;
	logic            top_c;
	logic [IDX_W-1:0] m_c;

	logic             valid_s1;
	logic [2:0]       kind_s1;
	logic             top_s1;
	logic [IDX_W-1:0] m_s1;

	logic [IDX_W+CFG_W-1:0] prod;
	logic [15:0]            ph_raw, ph_neg;

	assign s_ext    = (VIDX_W+1)'(cfg.slices);
	assign body_end = s_ext << 1;
	assign base1    = body_end + (VIDX_W+1)'(2);
	assign base2    = body_end + s_ext + (VIDX_W+1)'(4);
	assign last_idx = (s_ext << 2) + (VIDX_W+1)'(5);
	assign n_ext    = {1'b0, vertex_index};
	assign upper    = n_ext < base2;
	assign rel      = n_ext - (upper ? base1 : base2);
	assign rel_m1   = rel - (VIDX_W+1)'(1);

	always_comb begin
		kind_c = K_ERR;
		top_c  = !vertex_index[0];
		m_c    = IDX_W'(vertex_index >> 1);
		priority if (n_ext > last_idx) begin
			kind_c = K_ERR;
		end else if (n_ext < body_end) begin
			kind_c = K_BODY;
		end else if (n_ext < base1) begin
			kind_c = K_BCLOSE;
		end else begin
			top_c = upper;
			m_c   = IDX_W'(rel_m1);
			priority if (rel == '0) begin
				kind_c = K_CENTER;
			end else if (rel <= s_ext) begin
				kind_c = K_RING;
			end else begin
				kind_c = K_CCLOSE;
			end
		end
	end

	assign in_ready = !valid_s1 || !q_full;
	assign push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind_c;
			top_s1  <= top_c;
			m_s1    <= m_c;
		end
	end

	// phase wraps mod one turn; the lower cap ring runs backwards
	assign prod   = m_s1 * cfg.phase_step;
	assign ph_raw = prod[15:0];
	assign ph_neg = 16'd0 - ph_raw;

	always_comb begin
		push_item.kind  = kind_s1;
		push_item.top   = top_s1;
		push_item.m     = m_s1;
		push_item.phase = (kind_s1 == K_RING && !top_s1) ? ph_neg : ph_raw;
	end

endmodule

[src/cvg_queue.sv]
// Short FIFO of classified items between front and back.
// Depends on cvg_pkg for item_t and depth.
module cvg_queue import cvg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full     = count_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (Q_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (Q_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[src/cvg_back.sv]
// Back end: CORDIC rotation and texture divider in one stalling pipeline,
// then scaling and field assembly into the output register. Depends on cvg_pkg.
module cvg_back import cvg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      q_empty,
	input  item_t                     q_item,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] pos_x,
	output logic signed [FIELD_W-1:0] pos_y,
	output logic signed [FIELD_W-1:0] pos_z,
	output logic signed [FIELD_W-1:0] norm_x,
	output logic signed [FIELD_W-1:0] norm_y,
	output logic signed [FIELD_W-1:0] norm_z,
	output logic [FIELD_W-1:0]        tex_s,
	output logic [FIELD_W-1:0]        tex_t,
	output logic                      index_error
);

	function automatic logic signed [FIELD_W-1:0] clamp_unit(input logic signed [16:0] v);
		logic signed [FIELD_W-1:0] r;
		if (v > 17'sd16384) begin
			r = ONE_Q14;
		end else if (v < -17'sd16384) begin
			r = -ONE_Q14;
		end else begin
			r = v[FIELD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [FIELD_W-1:0] scale_pos(
		input logic signed [FIELD_W-1:0] u,
		input logic [CFG_W-1:0] rad
	);
		logic signed [31:0] p, sh;
		logic signed [FIELD_W-1:0] r;
		p  = u * $signed({1'b0, rad});
		sh = (p + 32'sd8192) >>> 14;
		if (sh > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (sh < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = sh[FIELD_W-1:0];
		end
		return r;
	endfunction

	logic       adv;
	stage_t     stage_s [PIPE_N+1];
	stage_t     stage_in;
	fin_t       fin_s1, fin_c;
	logic [16:0] ph_bias;
	logic [1:0]  quad_c;
	logic [15:0] r16;
	logic [TEX_W-1:0] half_s;

	logic                      out_valid_q, err_q;
	logic signed [FIELD_W-1:0] px_q, py_q, pz_q, nx_q, ny_q, nz_q;
	logic [FIELD_W-1:0]        ts_q, tt_q;
	logic signed [FIELD_W-1:0] px_c, py_c, pz_c, nx_c, ny_c, nz_c;
	logic [FIELD_W-1:0]        ts_c, tt_c;
	logic                      err_c;
	logic signed [FIELD_W-1:0] h_pos, rad_pos, cap_nz;
	logic [16:0]               tex_c, tex_s1;

	// whole pipeline holds while the output register is blocked
	assign adv    = !out_valid_q || out_ready;
	assign q_pop  = adv && !q_empty;
	assign half_s = TEX_W'(cfg.slices >> 1);

	// quadrant split: residual angle lands in [-1/8, 1/8) turn
	assign ph_bias = {1'b0, q_item.phase} + 17'd8192;
	assign quad_c  = ph_bias[15:14];
	assign r16     = q_item.phase - {quad_c, 14'b0};

	always_comb begin
		stage_in.valid = !q_empty;
		stage_in.kind  = q_item.kind;
		stage_in.top   = q_item.top;
		stage_in.quad  = quad_c;
		stage_in.x     = 32'(CORDIC_GAIN_Q30);
		stage_in.y     = '0;
		stage_in.z     = $signed({r16, 16'b0});
		stage_in.rem   = SLICE_W'(q_item.m);
		stage_in.quo   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s[0] <= '0;
		end else if (adv) begin
			stage_s[0] <= stage_in;
		end
	end

	for (genvar k = 0; k < PIPE_N; k++) begin : g_stage
		stage_t             cur, nxt;
		logic signed [31:0] x_n, y_n, z_n;
		logic [SLICE_W-1:0] rem_n;
		logic [TEX_W-1:0]   quo_n;

		assign cur = stage_s[k];

		if (k < CORDIC_N) begin : g_rot
			logic signed [31:0] xs, ys, at;
			assign xs = $signed(cur.x) >>> k;
			assign ys = $signed(cur.y) >>> k;
			assign at = 32'(ATAN_TURN[k]);
			always_comb begin
				if (!cur.z[31]) begin
					x_n = $signed(cur.x) - ys;
					y_n = $signed(cur.y) + xs;
					z_n = $signed(cur.z) - at;
				end else begin
					x_n = $signed(cur.x) + ys;
					y_n = $signed(cur.y) - xs;
					z_n = $signed(cur.z) + at;
				end
			end
		end else begin : g_rot_hold
			assign x_n = cur.x;
			assign y_n = cur.y;
			assign z_n = cur.z;
		end

		// one quotient bit of (i*32768 + S/2) / S per stage
		if (k < TEX_W) begin : g_div
			logic [SLICE_W:0] rem2, diff;
			logic             take;
			assign rem2  = {cur.rem, half_s[TEX_W-1-k]};
			assign take  = rem2 >= {1'b0, cfg.slices};
			assign diff  = rem2 - {1'b0, cfg.slices};
			assign rem_n = take ? diff[SLICE_W-1:0] : rem2[SLICE_W-1:0];
			assign quo_n = {cur.quo[TEX_W-2:0], take};
		end else begin : g_div_hold
			assign rem_n = cur.rem;
			assign quo_n = cur.quo;
		end

		always_comb begin
			nxt     = cur;
			nxt.x   = x_n;
			nxt.y   = y_n;
			nxt.z   = z_n;
			nxt.rem = rem_n;
			nxt.quo = quo_n;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_s[k+1] <= '0;
			end else if (adv) begin
				stage_s[k+1] <= nxt;
			end
		end
	end

	// round to Q1.14, undo quadrant split, clamp
	always_comb begin
		logic signed [32:0] xr, yr;
		logic signed [16:0] c0, s0, cr, sr;
		xr = $signed({stage_s[PIPE_N].x[31], stage_s[PIPE_N].x}) + 33'sd32768;
		yr = $signed({stage_s[PIPE_N].y[31], stage_s[PIPE_N].y}) + 33'sd32768;
		c0 = xr[32:16];
		s0 = yr[32:16];
		unique case (stage_s[PIPE_N].quad)
			2'd0: begin cr = c0;  sr = s0;  end
			2'd1: begin cr = -s0; sr = c0;  end
			2'd2: begin cr = -c0; sr = -s0; end
			2'd3: begin cr = s0;  sr = -c0; end
			default: begin cr = c0; sr = s0; end
		endcase
		fin_c.valid = stage_s[PIPE_N].valid;
		fin_c.kind  = stage_s[PIPE_N].kind;
		fin_c.top   = stage_s[PIPE_N].top;
		fin_c.quo   = stage_s[PIPE_N].quo;
		fin_c.c     = clamp_unit(cr);
		fin_c.s     = clamp_unit(sr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s1 <= '0;
		end else if (adv) begin
			fin_s1 <= fin_c;
		end
	end

	assign h_pos   = fin_s1.top ? $signed({1'b0, cfg.half_length})
	                            : -$signed({1'b0, cfg.half_length});
	assign rad_pos = $signed({1'b0, cfg.radius});
	assign cap_nz  = fin_s1.top ? ONE_Q14 : -ONE_Q14;
	assign tex_c   = 17'($signed(fin_s1.c) + 17'sd16384);
	assign tex_s1  = 17'($signed(fin_s1.s) + 17'sd16384);

	always_comb begin
		px_c  = '0;
		py_c  = '0;
		pz_c  = '0;
		nx_c  = '0;
		ny_c  = '0;
		nz_c  = '0;
		ts_c  = '0;
		tt_c  = '0;
		err_c = 1'b0;
		unique case (fin_s1.kind)
			K_ERR: begin
				err_c = 1'b1;
			end
			K_BODY: begin
				px_c = scale_pos(fin_s1.c, cfg.radius);
				py_c = scale_pos(fin_s1.s, cfg.radius);
				pz_c = h_pos;
				nx_c = fin_s1.c;
				ny_c = fin_s1.s;
				ts_c = FIELD_W'(fin_s1.quo);
				tt_c = fin_s1.top ? ONE_Q15 : '0;
			end
			K_BCLOSE: begin
				px_c = rad_pos;
				pz_c = h_pos;
				nx_c = ONE_Q14;
				ts_c = ONE_Q15;
				tt_c = fin_s1.top ? ONE_Q15 : '0;
			end
			K_CENTER: begin
				pz_c = h_pos;
				nz_c = cap_nz;
				ts_c = HALF_Q15;
				tt_c = HALF_Q15;
			end
			K_RING: begin
				px_c = scale_pos(fin_s1.c, cfg.radius);
				py_c = scale_pos(fin_s1.s, cfg.radius);
				pz_c = h_pos;
				nz_c = cap_nz;
				ts_c = tex_c[FIELD_W-1:0];
				tt_c = tex_s1[FIELD_W-1:0];
			end
			K_CCLOSE: begin
				px_c = rad_pos;
				pz_c = h_pos;
				nz_c = cap_nz;
				ts_c = ONE_Q15;
				tt_c = HALF_Q15;
			end
			default: begin
				err_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fin_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q  <= px_c;
			py_q  <= py_c;
			pz_q  <= pz_c;
			nx_q  <= nx_c;
			ny_q  <= ny_c;
			nz_q  <= nz_c;
			ts_q  <= ts_c;
			tt_q  <= tt_c;
			err_q <= err_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = px_q;
	assign pos_y       = py_q;
	assign pos_z       = pz_q;
	assign norm_x      = nx_q;
	assign norm_y      = ny_q;
	assign norm_z      = nz_q;
	assign tex_s       = ts_q;
	assign tex_t       = tt_q;
	assign index_error = err_q;

endmodule

[src/cvg_checker.sv]
// Port-level checks for the cylinder vertex generator, bound to the top level.
// Depends on cvg_pkg for widths and fixed-point constants.
module cvg_checker import cvg_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [CFG_IDX_W-1:0]      cfg_index,
	input logic [CFG_W-1:0]          cfg_data,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [VIDX_W-1:0]         vertex_index,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [FIELD_W-1:0] pos_x,
	input logic signed [FIELD_W-1:0] pos_y,
	input logic signed [FIELD_W-1:0] pos_z,
	input logic signed [FIELD_W-1:0] norm_x,
	input logic signed [FIELD_W-1:0] norm_y,
	input logic signed [FIELD_W-1:0] norm_z,
	input logic [FIELD_W-1:0]        tex_s,
	input logic [FIELD_W-1:0]        tex_t,
	input logic                      index_error
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(tex_s)
			&& $stable(index_error))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> pos_x == 0 && pos_y == 0 && pos_z == 0
			&& norm_x == 0 && norm_y == 0 && norm_z == 0 && tex_s == 0 && tex_t == 0)
		else $error("error result carries nonzero fields");

	// cap normals are pure +Z or -Z
	a_cap_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && norm_z != 0 |-> norm_x == 0 && norm_y == 0
			&& (norm_z == ONE_Q14 || norm_z == -ONE_Q14))
		else $error("malformed cap normal");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tex_s <= ONE_Q15 && tex_t <= ONE_Q15)
		else $error("texture coordinate above 1.0");

endmodule

bind cylinder_vertex_generator_top cvg_checker u_cvg_checker (.*);
